[hw/rtl/crc16_response_frame_checker_defines.svh]
// Assertion macros for the frame checker's port-level assertions.
`ifndef CRC16_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define CRC16_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Implication in the same cycle, disabled during reset.
`define CRCFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Frame checker assertion failed.");

// Implication into the next cycle, disabled during reset.
`define CRCFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Frame checker assertion failed.");

// Implication into the next cycle, also checked while reset is high.
`define CRCFC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("Frame checker assertion failed.");

`endif

[hw/rtl/crcfc_pkg.sv]
// Types, constants and the CRC byte update shared by the frame checker.
package crcfc_pkg;

   typedef logic [5:0] count_type;

   localparam count_type FRAME_LEN = 6'd35;
   localparam count_type CRC_LEN = 6'd33;
   localparam count_type LAST_IDX = 6'd34;
   localparam count_type SER_HI_FIRST = 6'd1;
   localparam count_type SER_HI_LAST = 6'd4;
   localparam count_type SER_LO_FIRST = 6'd9;
   localparam count_type SER_LO_LAST = 6'd13;
   localparam logic [15:0] CRC_POLY = 16'h8005;

   typedef struct packed {
      logic        crc_ok;
      logic [15:0] computed_crc;
      logic [31:0] serial_high;
      logic [39:0] serial_low;
      logic        serial_valid;
   } result_type;

   // Feeds one byte, least significant bit first, into the non-reflected register.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = b[i] ^ c[15];
         c = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

[hw/rtl/crcfc_frame_core.sv]
// Frame position, CRC register, serial capture and held serial of the checker.
module crcfc_frame_core import crcfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       frame_start,
   output logic       emit,
   output result_type result
);

   count_type   byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  rx_low_ff, rx_low_in;
   logic [31:0] frame_hi_ff, frame_hi_in;
   logic [39:0] frame_lo_ff, frame_lo_in;
   logic [31:0] held_hi_ff, held_hi_in;
   logic [39:0] held_lo_ff, held_lo_in;
   logic        held_valid_ff, held_valid_in;

   count_type   idx;
   logic        active;
   logic        crc_match;
   logic [15:0] crc_base;
   logic [7:0]  rx_low_base;
   logic [31:0] frame_hi_base;
   logic [39:0] frame_lo_base;

   always_comb begin
      idx = frame_start ? '0 : byte_count_ff;
      active = idx < FRAME_LEN;
      crc_base = frame_start ? '0 : crc_ff;
      rx_low_base = frame_start ? '0 : rx_low_ff;
      frame_hi_base = frame_start ? '0 : frame_hi_ff;
      frame_lo_base = frame_start ? '0 : frame_lo_ff;
      emit = active && (idx == LAST_IDX);
      crc_match = (rx_low_ff == crc_ff[7:0]) && (data_byte == crc_ff[15:8]);
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in = crc_ff;
      rx_low_in = rx_low_ff;
      frame_hi_in = frame_hi_ff;
      frame_lo_in = frame_lo_ff;
      held_hi_in = held_hi_ff;
      held_lo_in = held_lo_ff;
      held_valid_in = held_valid_ff;
      if (step && active) begin
         byte_count_in = idx + 6'd1;
         crc_in = crc_base;
         rx_low_in = rx_low_base;
         frame_hi_in = frame_hi_base;
         frame_lo_in = frame_lo_base;
         if (idx < CRC_LEN) begin
            crc_in = crc_byte(crc_base, data_byte);
         end
         if (idx >= SER_HI_FIRST && idx <= SER_HI_LAST) begin
            frame_hi_in = {frame_hi_base[23:0], data_byte};
         end
         if (idx >= SER_LO_FIRST && idx <= SER_LO_LAST) begin
            frame_lo_in = {frame_lo_base[31:0], data_byte};
         end
         if (idx == CRC_LEN) begin
            rx_low_in = data_byte;
         end
         if (emit && crc_match) begin
            held_hi_in = frame_hi_ff;
            held_lo_in = frame_lo_ff;
            held_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      result.crc_ok = crc_match;
      result.computed_crc = crc_ff;
      result.serial_high = crc_match ? frame_hi_ff : held_hi_ff;
      result.serial_low = crc_match ? frame_lo_ff : held_lo_ff;
      result.serial_valid = crc_match | held_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= FRAME_LEN;
         crc_ff <= '0;
         rx_low_ff <= '0;
         frame_hi_ff <= '0;
         frame_lo_ff <= '0;
         held_hi_ff <= '0;
         held_lo_ff <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         crc_ff <= crc_in;
         rx_low_ff <= rx_low_in;
         frame_hi_ff <= frame_hi_in;
         frame_lo_ff <= frame_lo_in;
         held_hi_ff <= held_hi_in;
         held_lo_ff <= held_lo_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

[hw/rtl/crc16_response_frame_checker.sv]
// Top level of the CRC-16 response frame checker.
//
// Bytes of a 35-byte response frame enter on the req_ channel, one item per
// byte; req_frame_start marks byte 0 and restarts the count and the CRC.
// Bytes 0 to 32 go through a CRC-16 (polynomial 0x8005, initial value 0, each
// byte least significant bit first), and bytes 33 and 34 are compared with it
// as the stored CRC, low byte first. Bytes 1-4 and 9-13 form the serial.
// After byte 34 one item leaves on the rsp_ channel with the check result,
// the computed CRC and the held serial, which is updated only on a match.
// Bytes outside a frame are accepted and dropped without a result.
// A byte is registered at the input and then processed into the result
// register, so a frame's result passes both registers before rsp_valid rises.
// One byte per cycle is sustained while no result waits on a stalled receiver;
// the combinational CRC byte update between the two registers allows that rate.
// Reset empties both registers and leaves the block idle with no held serial.
// When the receiver stalls, a waiting result holds; a byte that causes no
// result still passes, and the input stalls only when a second result is due.
module crc16_response_frame_checker import crcfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_crc_ok,
   output logic [15:0] rsp_computed_crc,
   output logic [31:0] rsp_serial_high,
   output logic [39:0] rsp_serial_low,
   output logic        rsp_serial_valid
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_start_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;

   logic       step;
   logic       emit;
   logic       out_free;
   result_type result;

   crcfc_frame_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_data_ff),
      .frame_start (in_start_ff),
      .emit        (emit),
      .result      (result)
   );

   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      step = in_valid_ff && (!emit || out_free);
      req_ready = !in_valid_ff || step;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
      if (step && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_crc_ok = out_data_ff.crc_ok;
   assign rsp_computed_crc = out_data_ff.computed_crc;
   assign rsp_serial_high = out_data_ff.serial_high;
   assign rsp_serial_low = out_data_ff.serial_low;
   assign rsp_serial_valid = out_data_ff.serial_valid;

endmodule

[hw/rtl/crcfc_checker.sv]
// Port-level assertions for the frame checker and the bind that attaches them.
`include "crc16_response_frame_checker_defines.svh"

module crcfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_crc_ok,
   input logic [15:0] rsp_computed_crc,
   input logic [39:0] rsp_serial_low,
   input logic        rsp_serial_valid
);

   // Nothing is shown in the cycle after reset.
   `CRCFC_ASSERT_NEXT_ALWAYS(a_rsp_idle_after_reset, clock, reset, !rsp_valid)

   // A stalled result stays valid and keeps its computed CRC and low serial.
   `CRCFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_computed_crc) && $stable(rsp_serial_low))

   // A passing frame always leaves a valid serial behind.
   `CRCFC_ASSERT_IMPLY(a_ok_sets_valid, clock, reset, rsp_valid && rsp_crc_ok,
      rsp_serial_valid)

   // The input only stalls while a result is waiting downstream.
   `CRCFC_ASSERT_IMPLY(a_stall_cause, clock, reset, req_valid && !req_ready,
      rsp_valid && !rsp_ready)

endmodule

bind crc16_response_frame_checker crcfc_checker u_crcfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_crc_ok       (rsp_crc_ok),
   .rsp_computed_crc (rsp_computed_crc),
   .rsp_serial_low   (rsp_serial_low),
   .rsp_serial_valid (rsp_serial_valid)
);

[dv/testbench.sv]
// Self-checking testbench for the CRC-16 response frame checker.
`timescale 1ns / 100ps

module testbench;
   import crcfc_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } link_byte_type;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;
   typedef enum {CRC_GOOD, CRC_BAD_LOW, CRC_BAD_HIGH, CRC_RANDOM} crc_kind_type;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_AFTER = 400;
   localparam int QUIET_TAIL_ITEMS = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_frame_start = 1'b0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire         rsp_crc_ok;
   wire  [15:0] rsp_computed_crc;
   wire  [31:0] rsp_serial_high;
   wire  [39:0] rsp_serial_low;
   wire         rsp_serial_valid;

   link_byte_type bytes_to_send[$];
   result_type frame_results_due[$];

   count_type   frame_pos = FRAME_LEN;
   logic [15:0] running_crc = '0;
   logic [7:0]  stored_crc_low = '0;
   logic [31:0] frame_ser_high = '0;
   logic [39:0] frame_ser_low = '0;
   logic [31:0] kept_ser_high = '0;
   logic [39:0] kept_ser_low = '0;
   logic        kept_valid = 1'b0;

   int            fail_count = 0;
   int            bytes_accepted = 0;
   int            tx_gap = 0;
   int            rx_gap = 0;
   int            hold_left = 0;
   bit            long_hold_done = 1'b0;
   bit            quiet_tail = 1'b0;
   link_byte_type next_byte;
   result_type    got_result;
   result_type    want_result;

   crc16_response_frame_checker i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_serial_high  (rsp_serial_high),
      .rsp_serial_low   (rsp_serial_low),
      .rsp_serial_valid (rsp_serial_valid)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_lsb_first(input logic [15:0] acc,
                                                    input logic [7:0] data);
      logic [15:0] r;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         if (r[15] != data[k]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Advances the frame state by one accepted byte and queues the result it causes.
   task automatic track_frame_byte(input logic [7:0] b, input logic start);
      count_type  pos;
      result_type r;
      if (start) begin
         pos = '0;
         running_crc = '0;
         stored_crc_low = '0;
         frame_ser_high = '0;
         frame_ser_low = '0;
      end else begin
         pos = frame_pos;
      end
      if (pos < FRAME_LEN) begin
         frame_pos = pos + 1'b1;
         if (pos < CRC_LEN) begin
            running_crc = crc16_lsb_first(running_crc, b);
            if (pos >= SER_HI_FIRST && pos <= SER_HI_LAST) begin
               frame_ser_high = {frame_ser_high[23:0], b};
            end else if (pos >= SER_LO_FIRST && pos <= SER_LO_LAST) begin
               frame_ser_low = {frame_ser_low[31:0], b};
            end
         end else if (pos == CRC_LEN) begin
            stored_crc_low = b;
         end else begin
            r.crc_ok = (stored_crc_low == running_crc[7:0]) && (b == running_crc[15:8]);
            if (r.crc_ok) begin
               kept_ser_high = frame_ser_high;
               kept_ser_low = frame_ser_low;
               kept_valid = 1'b1;
            end
            r.computed_crc = running_crc;
            r.serial_high = kept_ser_high;
            r.serial_low = kept_ser_low;
            r.serial_valid = kept_valid;
            frame_results_due.push_back(r);
         end
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic start);
      link_byte_type item;
      item.data = b;
      item.start = start;
      bytes_to_send.push_back(item);
   endtask

   // Queues the first cut bytes of a frame whose stored CRC is shaped by how.
   task automatic queue_frame(input fill_kind_type fill, input crc_kind_type how,
                              input int cut);
      logic [7:0]  frame_bytes [0:FRAME_LEN-1];
      logic [15:0] c;
      c = '0;
      for (int i = 0; i < CRC_LEN; i++) begin
         case (fill)
            FILL_ZERO: frame_bytes[i] = 8'h00;
            FILL_ONES: frame_bytes[i] = 8'hFF;
            default: frame_bytes[i] = 8'($urandom);
         endcase
         c = crc16_lsb_first(c, frame_bytes[i]);
      end
      frame_bytes[CRC_LEN] = c[7:0];
      frame_bytes[LAST_IDX] = c[15:8];
      case (how)
         CRC_BAD_LOW: frame_bytes[CRC_LEN] ^= 8'(1 << $urandom_range(7, 0));
         CRC_BAD_HIGH: frame_bytes[LAST_IDX] ^= 8'(1 << $urandom_range(7, 0));
         CRC_RANDOM: begin
            frame_bytes[CRC_LEN] = 8'($urandom);
            frame_bytes[LAST_IDX] = 8'($urandom);
         end
         default: ;
      endcase
      for (int i = 0; i < cut; i++) begin
         push_byte(frame_bytes[i], i == 0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'h00;
         req_frame_start <= 1'b0;
         tx_gap = 0;
         frame_pos = FRAME_LEN;
         running_crc = '0;
         stored_crc_low = '0;
         frame_ser_high = '0;
         frame_ser_low = '0;
         kept_ser_high = '0;
         kept_ser_low = '0;
         kept_valid = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_frame_byte(req_data_byte, req_frame_start);
            bytes_accepted++;
         end
         quiet_tail = bytes_to_send.size() < QUIET_TAIL_ITEMS;
         if (!req_valid || req_ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() > 0 && !quiet_tail &&
                         $urandom_range(11, 0) == 0) begin
               tx_gap = $urandom_range(18, 1) - 1;
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() > 0) begin
               next_byte = bytes_to_send.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_byte.data;
               req_frame_start <= next_byte.start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_gap = 0;
         hold_left = 0;
      end else if (!long_hold_done && bytes_accepted >= LONG_HOLD_AFTER) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(9, 0) == 0) begin
         rx_gap = $urandom_range(18, 1) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_result.crc_ok = rsp_crc_ok;
         got_result.computed_crc = rsp_computed_crc;
         got_result.serial_high = rsp_serial_high;
         got_result.serial_low = rsp_serial_low;
         got_result.serial_valid = rsp_serial_valid;
         if (frame_results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("Unexpected result item: ok %0d crc %h serial %h_%h valid %0d",
                        got_result.crc_ok, got_result.computed_crc,
                        got_result.serial_high, got_result.serial_low,
                        got_result.serial_valid);
            end
         end else begin
            want_result = frame_results_due.pop_front();
            if (got_result.crc_ok !== want_result.crc_ok ||
                got_result.computed_crc !== want_result.computed_crc ||
                got_result.serial_high !== want_result.serial_high ||
                got_result.serial_low !== want_result.serial_low ||
                got_result.serial_valid !== want_result.serial_valid) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("Mismatch (expected/actual): ok %0d/%0d crc %h/%h",
                           want_result.crc_ok, got_result.crc_ok,
                           want_result.computed_crc, got_result.computed_crc);
                  $display("   serial %h_%h/%h_%h valid %0d/%0d",
                           want_result.serial_high, want_result.serial_low,
                           got_result.serial_high, got_result.serial_low,
                           want_result.serial_valid, got_result.serial_valid);
               end
            end
         end
      end
   end

   initial begin
      int            frames_queued;
      int            useful_items;
      int            pick;
      int            cut;
      fill_kind_type fill;
      crc_kind_type  how;
      frames_queued = 0;
      useful_items = 0;

      // Bytes while idle, a frame cut short by the next start, then full frames.
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'($urandom), 1'b0);
      queue_frame(FILL_ONES, CRC_GOOD, 12);
      queue_frame(FILL_ONES, CRC_GOOD, FRAME_LEN);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      queue_frame(FILL_ZERO, CRC_BAD_HIGH, FRAME_LEN);
      queue_frame(FILL_ZERO, CRC_BAD_LOW, FRAME_LEN);
      queue_frame(FILL_ZERO, CRC_GOOD, FRAME_LEN);
      frames_queued = 4;
      useful_items = 3 * FRAME_LEN + 12;

      while (frames_queued < 16 || useful_items < 800) begin
         pick = $urandom_range(99, 0);
         case ($urandom_range(19, 0))
            0: fill = FILL_ZERO;
            1, 2: fill = FILL_ONES;
            default: fill = FILL_RANDOM;
         endcase
         case ($urandom_range(9, 0))
            6: how = CRC_BAD_LOW;
            7: how = CRC_BAD_HIGH;
            8, 9: how = CRC_RANDOM;
            default: how = CRC_GOOD;
         endcase
         if (pick < 75) begin
            queue_frame(fill, how, FRAME_LEN);
            frames_queued++;
            useful_items += FRAME_LEN;
         end else if (pick < 88) begin
            cut = $urandom_range(LAST_IDX, 1);
            queue_frame(fill, how, cut);
            useful_items += cut;
         end else begin
            repeat ($urandom_range(4, 1)) push_byte(8'($urandom), 1'b0);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (bytes_to_send.size() != 0 || req_valid) @(posedge clock);
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && frame_results_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
